>>> design/clbs_pkg.sv
package clbs_pkg;

  // Tick counter width used by the sequencer unless overridden.
  localparam int unsigned CountWidthDef = 18;

  // Timing registers are all 18 bits wide.
  localparam int unsigned RegW = 18;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register indexes on the configuration port.
  typedef enum logic [RegIdxW-1:0] {
    REG_SETUP      = 3'd0,
    REG_ENABLE     = 3'd1,
    REG_HOLD       = 3'd2,
    REG_READ       = 3'd3,
    REG_GAP        = 3'd4,
    REG_CMD_WAIT   = 3'd5,
    REG_CHAR_WAIT  = 3'd6,
    REG_CLEAR_WAIT = 3'd7
  } reg_idx_e;

  typedef logic [RegW-1:0] reg_val_t;

  // Reset values of the timing registers, in register index order.
  localparam reg_val_t RegReset [NumRegs] = '{
    18'd4, 18'd25, 18'd1, 18'd36, 18'd800, 18'd3900, 18'd4300, 18'd200000
  };

  // Request codes carried by an input word.
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_RAW_CMD   = 3'd1,
    OP_DATA_CHAR = 3'd2,
    OP_SET_CURS  = 3'd3,
    OP_FUNC_SET  = 3'd4,
    OP_DISP_CTRL = 3'd5,
    OP_ENTRY     = 3'd6,
    OP_CLEAR     = 3'd7
  } op_e;

  // Bus sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_POLL_HIGH = 3'd1,
    PH_POLL_LOW  = 3'd2,
    PH_GAP       = 3'd3,
    PH_SETUP     = 3'd4,
    PH_ENABLE    = 3'd5,
    PH_HOLD      = 3'd6,
    PH_WAIT      = 3'd7
  } phase_e;

  // Which delay follows the byte write.
  typedef enum logic [1:0] {
    WAIT_CMD   = 2'd0,
    WAIT_CHAR  = 2'd1,
    WAIT_CLEAR = 2'd2
  } wait_sel_e;

  // Command byte building blocks.
  localparam logic [7:0] SetDdramBit  = 8'h80;
  localparam logic [7:0] FuncSetBase  = 8'h30;
  localparam logic [7:0] TwoRowsBit   = 8'h08;
  localparam logic [7:0] BigFontBit   = 8'h04;
  localparam logic [7:0] DispCtrlBase = 8'h08;
  localparam logic [7:0] EntryBase    = 8'h04;
  localparam logic [7:0] ClearCmd     = 8'h01;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] value;
    logic [6:0] column;
    logic [1:0] row;
    logic [2:0] flags;
    logic [7:0] bus_in;
  } in_item_t;

  typedef struct packed {
    logic       enable_pin;
    logic       select_pin;
    logic       read_pin;
    logic [7:0] data_out;
    logic       drive_data;
    logic       ready_res;
    logic       rejected;
  } out_item_t;

endpackage

>>> design/char_lcd_bus_sequencer.sv
// The result word for an input word is registered as it is accepted. Throughput: one
// input word per cycle unless stalled; the phase and tick counter advance once per word,
// and a single output register decouples the two sides so input flows while it drains.
// Reset: timing registers return to their defaults, the sequencer goes idle with E, RS
// and RW low, the data pins driven as outputs holding zero, and the output register empty.
module char_lcd_bus_sequencer #(
  parameter int unsigned COUNT_WIDTH = clbs_pkg::CountWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request words
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  clbs_pkg::in_item_t              in_item_i,
  // Pin state words
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output clbs_pkg::out_item_t             out_item_o,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [clbs_pkg::AddrW-1:0]      paddr,
  input  logic [clbs_pkg::DataW-1:0]      pwdata,
  output logic [clbs_pkg::DataW-1:0]      prdata,
  output logic                            pready
);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Timing registers.
  clbs_pkg::reg_val_t cfg_q [clbs_pkg::NumRegs];

  // Sequencer state.
  clbs_pkg::phase_e    phase_q, phase_d;
  count_t              count_q, count_d;
  logic [7:0]          pend_byte_q, pend_byte_d;
  logic                pend_data_q, pend_data_d;
  clbs_pkg::wait_sel_e wait_sel_q, wait_sel_d;
  logic                pin_en_q, pin_en_d;
  logic                pin_sel_q, pin_sel_d;
  logic                pin_rd_q, pin_rd_d;
  logic [7:0]          pin_data_q, pin_data_d;
  logic                pin_drive_q, pin_drive_d;
  logic                rejected;

  // Output register.
  logic                out_valid_q;
  clbs_pkg::out_item_t out_q, res;

  logic                in_accept;
  logic                cfg_write;
  logic [clbs_pkg::RegIdxW-1:0] cfg_idx;

  // Low COUNT_WIDTH bits of a timing register.
  function automatic count_t dur(input clbs_pkg::reg_val_t r);
    return COUNT_WIDTH'(r);
  endfunction

  // Phases where E is strobed last at least one tick.
  function automatic count_t dur_min1(input clbs_pkg::reg_val_t r);
    count_t d;
    d = COUNT_WIDTH'(r);
    return (d == '0) ? count_t'(1) : d;
  endfunction

  // Configuration port: always ready, word addressed.
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[clbs_pkg::AddrW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = clbs_pkg::DataW'(cfg_q[cfg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= clbs_pkg::RegReset;
    end else if (cfg_write) begin
      cfg_q[cfg_idx] <= pwdata[clbs_pkg::RegW-1:0];
    end
  end

  // Handshake: a new word enters whenever the output register can take the result.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // One tick of the sequencer: accept or count down, then enter the next phase,
  // passing through any phases whose duration is zero.
  always_comb begin : seq_step
    logic             start;
    clbs_pkg::phase_e ph;
    clbs_pkg::phase_e nxt;
    count_t           d;
    logic             done;
    logic [7:0]       byte_v;
    logic [7:0]       curs_low;

    phase_d     = phase_q;
    count_d     = count_q;
    pend_byte_d = pend_byte_q;
    pend_data_d = pend_data_q;
    wait_sel_d  = wait_sel_q;
    pin_en_d    = pin_en_q;
    pin_sel_d   = pin_sel_q;
    pin_rd_d    = pin_rd_q;
    pin_data_d  = pin_data_q;
    pin_drive_d = pin_drive_q;
    rejected    = 1'b0;
    start       = 1'b0;
    ph          = clbs_pkg::PH_IDLE;
    nxt         = clbs_pkg::PH_IDLE;
    d           = '0;
    done        = 1'b0;
    byte_v      = '0;
    curs_low    = 8'({in_item_i.row - 2'd1, 6'd0}) + 8'(in_item_i.column) + 8'hFF;

    if (phase_q == clbs_pkg::PH_IDLE) begin
      // Build the byte for a new request.
      if (clbs_pkg::op_e'(in_item_i.opcode) != clbs_pkg::OP_TICK) begin
        pend_data_d = 1'b0;
        wait_sel_d  = clbs_pkg::WAIT_CMD;
        case (clbs_pkg::op_e'(in_item_i.opcode))
          clbs_pkg::OP_RAW_CMD: begin
            byte_v = in_item_i.value;
          end
          clbs_pkg::OP_DATA_CHAR: begin
            byte_v      = in_item_i.value;
            pend_data_d = 1'b1;
            wait_sel_d  = clbs_pkg::WAIT_CHAR;
          end
          clbs_pkg::OP_SET_CURS: begin
            byte_v = clbs_pkg::SetDdramBit | curs_low;
          end
          clbs_pkg::OP_FUNC_SET: begin
            byte_v = clbs_pkg::FuncSetBase
                   | (in_item_i.flags[1] ? clbs_pkg::TwoRowsBit : 8'h00)
                   | (in_item_i.flags[0] ? clbs_pkg::BigFontBit : 8'h00);
          end
          clbs_pkg::OP_DISP_CTRL: begin
            byte_v = clbs_pkg::DispCtrlBase | 8'(in_item_i.flags);
          end
          clbs_pkg::OP_ENTRY: begin
            byte_v = clbs_pkg::EntryBase | 8'(in_item_i.flags[1:0]);
          end
          default: begin
            byte_v     = clbs_pkg::ClearCmd;
            wait_sel_d = clbs_pkg::WAIT_CLEAR;
          end
        endcase
        pend_byte_d = byte_v;
        start       = 1'b1;
        ph          = (clbs_pkg::op_e'(in_item_i.opcode) == clbs_pkg::OP_SET_CURS)
                    ? clbs_pkg::PH_SETUP : clbs_pkg::PH_POLL_HIGH;
      end
    end else begin
      rejected = (clbs_pkg::op_e'(in_item_i.opcode) != clbs_pkg::OP_TICK);
      if (count_q > count_t'(1)) begin
        count_d = count_q - count_t'(1);
      end else begin
        start = 1'b1;
        case (phase_q)
          clbs_pkg::PH_POLL_HIGH: begin
            ph = in_item_i.bus_in[7] ? clbs_pkg::PH_POLL_LOW : clbs_pkg::PH_GAP;
          end
          clbs_pkg::PH_POLL_LOW: ph = clbs_pkg::PH_POLL_HIGH;
          clbs_pkg::PH_GAP:      ph = clbs_pkg::PH_SETUP;
          clbs_pkg::PH_SETUP:    ph = clbs_pkg::PH_ENABLE;
          clbs_pkg::PH_ENABLE:   ph = clbs_pkg::PH_HOLD;
          clbs_pkg::PH_HOLD:     ph = clbs_pkg::PH_WAIT;
          default:               ph = clbs_pkg::PH_IDLE;
        endcase
      end
    end

    // Phase entry; at most two zero-length phases are passed in a row.
    if (start) begin
      for (int i = 0; i < 3; i++) begin
        if (!done) begin
          d   = '0;
          nxt = clbs_pkg::PH_IDLE;
          case (ph)
            clbs_pkg::PH_POLL_HIGH: begin
              pin_sel_d   = 1'b0;
              pin_rd_d    = 1'b1;
              pin_drive_d = 1'b0;
              pin_en_d    = 1'b1;
              d           = dur_min1(cfg_q[clbs_pkg::REG_READ]);
            end
            clbs_pkg::PH_POLL_LOW: begin
              pin_en_d = 1'b0;
              d        = count_t'(1);
            end
            clbs_pkg::PH_GAP: begin
              pin_sel_d   = 1'b0;
              pin_rd_d    = 1'b0;
              pin_drive_d = 1'b1;
              pin_en_d    = 1'b0;
              d           = dur(cfg_q[clbs_pkg::REG_GAP]);
              nxt         = clbs_pkg::PH_SETUP;
            end
            clbs_pkg::PH_SETUP: begin
              pin_sel_d   = pend_data_d;
              pin_rd_d    = 1'b0;
              pin_drive_d = 1'b1;
              pin_en_d    = 1'b0;
              pin_data_d  = pend_byte_d;
              d           = dur(cfg_q[clbs_pkg::REG_SETUP]);
              nxt         = clbs_pkg::PH_ENABLE;
            end
            clbs_pkg::PH_ENABLE: begin
              pin_en_d = 1'b1;
              d        = dur_min1(cfg_q[clbs_pkg::REG_ENABLE]);
            end
            clbs_pkg::PH_HOLD: begin
              pin_en_d = 1'b0;
              d        = dur(cfg_q[clbs_pkg::REG_HOLD]);
              nxt      = clbs_pkg::PH_WAIT;
            end
            clbs_pkg::PH_WAIT: begin
              pin_en_d = 1'b0;
              case (wait_sel_d)
                clbs_pkg::WAIT_CHAR:  d = dur(cfg_q[clbs_pkg::REG_CHAR_WAIT]);
                clbs_pkg::WAIT_CLEAR: d = dur(cfg_q[clbs_pkg::REG_CLEAR_WAIT]);
                default:              d = dur(cfg_q[clbs_pkg::REG_CMD_WAIT]);
              endcase
            end
            default: begin
              done    = 1'b1;
              phase_d = clbs_pkg::PH_IDLE;
              count_d = '0;
            end
          endcase
          if (!done) begin
            if (d == '0) begin
              ph = nxt;
            end else begin
              done    = 1'b1;
              phase_d = ph;
              count_d = d;
            end
          end
        end
      end
    end
  end

  // Pin state word for this tick.
  always_comb begin
    res.enable_pin = pin_en_d;
    res.select_pin = pin_sel_d;
    res.read_pin   = pin_rd_d;
    res.data_out   = pin_data_d;
    res.drive_data = pin_drive_d;
    res.ready_res  = (phase_d == clbs_pkg::PH_IDLE);
    res.rejected   = rejected;
  end

  // Sequencer registers advance once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= clbs_pkg::PH_IDLE;
      count_q     <= '0;
      pend_byte_q <= '0;
      pend_data_q <= 1'b0;
      wait_sel_q  <= clbs_pkg::WAIT_CMD;
      pin_en_q    <= 1'b0;
      pin_sel_q   <= 1'b0;
      pin_rd_q    <= 1'b0;
      pin_data_q  <= '0;
      pin_drive_q <= 1'b1;
    end else if (in_accept) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      pend_byte_q <= pend_byte_d;
      pend_data_q <= pend_data_d;
      wait_sel_q  <= wait_sel_d;
      pin_en_q    <= pin_en_d;
      pin_sel_q   <= pin_sel_d;
      pin_rd_q    <= pin_rd_d;
      pin_data_q  <= pin_data_d;
      pin_drive_q <= pin_drive_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
